// ===== hdl/integer_text_formatter_defines.svh =====
// ---------------------------------------------------------------------------
// integer text formatter assertion macros
// property templates for the assertions of the emitter module
// ---------------------------------------------------------------------------
`ifndef INTEGER_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TEXT_FORMATTER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ITF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/itf_pkg.sv =====
// ---------------------------------------------------------------------------
// itf_pkg
// shared constants, types and character helpers of the text formatter
// ---------------------------------------------------------------------------
package itf_pkg;

  localparam int MAX_WIDTH   = 63;
  localparam int MAX_DIGITS  = 22;
  localparam int PREC_LIMIT  = MAX_WIDTH - 3;
  localparam int HEX_DIGITS  = 16;
  localparam int CONV_STEPS  = 64;
  localparam int CONV_W      = $clog2(CONV_STEPS);
  localparam int ND_W        = $clog2(MAX_DIGITS + 1);
  localparam int CNT_W       = $clog2(MAX_WIDTH + MAX_DIGITS + 4);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // radix codes
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // flag bit positions
  localparam int FLAG_LEFT   = 0;
  localparam int FLAG_PLUS   = 1;
  localparam int FLAG_SPACE  = 2;
  localparam int FLAG_ALT    = 3;
  localparam int FLAG_ZPAD   = 4;
  localparam int FLAG_LOWER  = 5;
  localparam int FLAG_SIGNED = 6;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_UPX   = "X";
  localparam logic [7:0] CH_LOW_A = "a";

  localparam int DIGIT_SET_LEN = 36;
  localparam logic [8*DIGIT_SET_LEN-1:0] DIGIT_SET =
    "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

  // one planned field, handed from the front end to the emitter
  typedef struct packed {
    digits_t          digits;
    logic [ND_W-1:0]  nd;
    logic [5:0]       zeros;
    logic [5:0]       pad;
    logic             has_sign;
    logic [7:0]       sign_ch;
    logic [1:0]       npre;
    logic [7:0]       x_ch;
    logic             left;
    logic             zero_pad;
    logic             upper;
    logic [CNT_W-1:0] total;
  } job_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    c = DIGIT_SET[8*(DIGIT_SET_LEN-1-int'(d)) +: 8];
    if (upper && c >= CH_LOW_A) begin
      c = c & ~CASE_BIT;
    end
    return c;
  endfunction

endpackage

// ===== hdl/itf_ifs.sv =====
// ---------------------------------------------------------------------------
// itf channel interfaces
// request channel and character channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface itf_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  base_select;
  logic [6:0]  format_flags;
  logic [5:0]  field_width;
  logic [5:0]  min_digits;

  modport source (
    output valid, value, base_select, format_flags, field_width, min_digits,
    input  ready
  );
  modport sink (
    input  valid, value, base_select, format_flags, field_width, min_digits,
    output ready
  );
endinterface

interface itf_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;

  modport source (output valid, char_out, last_char, input ready);
  modport sink   (input valid, char_out, last_char, output ready);
endinterface

// ===== hdl/itf_front.sv =====
// ---------------------------------------------------------------------------
// itf_front
// accepts a request, converts the magnitude to digits and plans the layout
// ---------------------------------------------------------------------------
module itf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  itf_req_if.sink       req_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output itf_pkg::job_t push_job_o
);
  import itf_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_SCAN, F_PUSH} fstate_e;

  fstate_e           state_q;
  logic [63:0]       mag_q;
  logic              is_oct_q, is_hex_q;
  logic [6:0]        flags_q;
  logic [5:0]        w_q, p_q;
  logic              has_sign_q;
  logic [7:0]        sign_ch_q;
  digits_t           digit_q;
  logic [CONV_W-1:0] cnt_q;
  logic [ND_W-1:0]   nd_q;
  logic              nz_q;

  logic              sgn_neg;
  logic [63:0]       mag_in;
  digits_t           dab_digits, oct_digits, hex_digits;
  logic [65:0]       mag_ext;

  assign sgn_neg = req_i.format_flags[FLAG_SIGNED] && req_i.value[63];
  assign mag_in  = sgn_neg ? (64'd0 - req_i.value) : req_i.value;
  assign mag_ext = {2'b00, mag_q};

  // one shift-and-add-3 step of the binary to bcd conversion
  always_comb begin
    logic [3:0] adj;
    logic       carry;
    carry = mag_q[63];
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj           = (digit_q[i] >= 4'd5) ? (digit_q[i] + 4'd3) : digit_q[i];
      dab_digits[i] = {adj[2:0], carry};
      carry         = adj[3];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      oct_digits[i] = {1'b0, mag_ext[3*i +: 3]};
      hex_digits[i] = (i < HEX_DIGITS) ? mag_q[(4*i) % 64 +: 4] : 4'd0;
    end
  end

  // layout plan
  logic [5:0]       prec, zeros;
  logic [1:0]       npre;
  logic [CNT_W-1:0] len, pad, wide_w;
  logic             left, lower;

  always_comb begin
    left   = flags_q[FLAG_LEFT];
    lower  = flags_q[FLAG_LOWER];
    prec   = (p_q == 6'd0) ? 6'd1 : p_q;
    zeros  = (prec > 6'(nd_q)) ? (prec - 6'(nd_q)) : 6'd0;
    npre   = 2'd0;
    if (flags_q[FLAG_ALT] && nz_q) begin
      if (is_hex_q) begin
        npre = 2'd2;
      end else if (is_oct_q && zeros == 6'd0) begin
        npre = 2'd1;
      end
    end
    len    = CNT_W'(has_sign_q) + CNT_W'(npre) + CNT_W'(zeros) + CNT_W'(nd_q);
    wide_w = CNT_W'(w_q);
    pad    = (wide_w > len) ? (wide_w - len) : '0;

    push_job_o.digits   = digit_q;
    push_job_o.nd       = nd_q;
    push_job_o.zeros    = zeros;
    push_job_o.pad      = pad[5:0];
    push_job_o.has_sign = has_sign_q;
    push_job_o.sign_ch  = sign_ch_q;
    push_job_o.npre     = npre;
    push_job_o.x_ch     = lower ? (CH_UPX | CASE_BIT) : CH_UPX;
    push_job_o.left     = left;
    push_job_o.zero_pad = flags_q[FLAG_ZPAD] && !left && (p_q == 6'd0);
    push_job_o.upper    = is_hex_q && !lower;
    push_job_o.total    = len + pad;
  end

  assign req_i.ready  = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (req_i.valid) begin
            mag_q    <= mag_in;
            is_oct_q <= (req_i.base_select == BASE_OCT);
            is_hex_q <= (req_i.base_select == BASE_HEX);
            flags_q  <= req_i.format_flags;
            w_q      <= (req_i.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                             : req_i.field_width;
            p_q      <= (req_i.min_digits > 6'(PREC_LIMIT)) ? 6'(PREC_LIMIT)
                                                             : req_i.min_digits;
            has_sign_q <= req_i.format_flags[FLAG_SIGNED] &&
                          (req_i.value[63] || req_i.format_flags[FLAG_PLUS] ||
                           req_i.format_flags[FLAG_SPACE]);
            if (sgn_neg) begin
              sign_ch_q <= CH_MINUS;
            end else if (req_i.format_flags[FLAG_PLUS]) begin
              sign_ch_q <= CH_PLUS;
            end else begin
              sign_ch_q <= CH_SPACE;
            end
            digit_q <= '0;
            cnt_q   <= '0;
            nd_q    <= ND_W'(1);
            nz_q    <= 1'b0;
            state_q <= F_CONV;
          end
        end
        F_CONV: begin
          if (is_oct_q || is_hex_q) begin
            digit_q <= is_hex_q ? hex_digits : oct_digits;
            cnt_q   <= '0;
            state_q <= F_SCAN;
          end else begin
            digit_q <= dab_digits;
            mag_q   <= {mag_q[62:0], 1'b0};
            cnt_q   <= cnt_q + 1'b1;
            if (cnt_q == CONV_W'(CONV_STEPS - 1)) begin
              state_q <= F_SCAN;
            end
          end
        end
        F_SCAN: begin
          // highest nonzero digit sets the digit count
          if (digit_q[cnt_q[ND_W-1:0]] != 4'd0) begin
            nd_q <= cnt_q[ND_W-1:0] + 1'b1;
            nz_q <= 1'b1;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CONV_W'(MAX_DIGITS - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/itf_fifo.sv =====
// ---------------------------------------------------------------------------
// itf_fifo
// short queue of planned fields between the front end and the emitter
// ---------------------------------------------------------------------------
module itf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  itf_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output itf_pkg::job_t pop_job_o
);
  import itf_pkg::*;

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/itf_back.sv =====
// ---------------------------------------------------------------------------
// itf_back
// emits a planned field segment by segment, one character per cycle unless stalled
// ---------------------------------------------------------------------------
`include "integer_text_formatter_defines.svh"

module itf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  itf_pkg::job_t pop_job_i,
  itf_chr_if.source     chr_o
);
  import itf_pkg::*;

  typedef enum logic [2:0] {
    PH_PADL = 3'd0,
    PH_SIGN = 3'd1,
    PH_PRE  = 3'd2,
    PH_ZPAD = 3'd3,
    PH_ZERO = 3'd4,
    PH_DIG  = 3'd5,
    PH_PADR = 3'd6,
    PH_IDLE = 3'd7
  } phase_e;

  localparam int NUM_SEG = 7;

  function automatic logic [CNT_W-1:0] seg_len(job_t j, phase_e ph);
    logic [CNT_W-1:0] r;
    unique case (ph)
      PH_PADL: r = (!j.left && !j.zero_pad) ? CNT_W'(j.pad) : '0;
      PH_SIGN: r = CNT_W'(j.has_sign);
      PH_PRE:  r = CNT_W'(j.npre);
      PH_ZPAD: r = j.zero_pad ? CNT_W'(j.pad) : '0;
      PH_ZERO: r = CNT_W'(j.zeros);
      PH_DIG:  r = CNT_W'(j.nd);
      PH_PADR: r = j.left ? CNT_W'(j.pad) : '0;
      PH_IDLE: r = '0;
    endcase
    return r;
  endfunction

  // first nonempty segment at or after start
  function automatic phase_e first_phase(job_t j, logic [3:0] start);
    phase_e r;
    r = PH_IDLE;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (4'(i) >= start && seg_len(j, phase_e'(3'(i))) != '0) begin
        r = phase_e'(3'(i));
      end
    end
    return r;
  endfunction

  phase_e           phase_q;
  job_t             job_q;
  logic [CNT_W-1:0] seg_cnt_q, rem_q;
  logic             out_valid_q, last_q;
  logic [7:0]       char_q;

  logic             busy, advance, emit, seg_end, in_digits;
  logic [ND_W-1:0]  dig_idx;
  logic [7:0]       ch;

  assign busy        = (phase_q != PH_IDLE);
  assign advance     = !out_valid_q || chr_o.ready;
  assign emit        = busy && advance;
  assign pop_ready_o = !busy;
  assign seg_end     = (seg_cnt_q + 1'b1) == seg_len(job_q, phase_q);
  assign in_digits   = (seg_cnt_q < CNT_W'(job_q.nd));
  assign dig_idx     = job_q.nd - 1'b1 - seg_cnt_q[ND_W-1:0];

  always_comb begin
    unique case (phase_q)
      PH_PADL: ch = CH_SPACE;
      PH_SIGN: ch = job_q.sign_ch;
      PH_PRE:  ch = (seg_cnt_q == '0) ? CH_ZERO : job_q.x_ch;
      PH_ZPAD: ch = CH_ZERO;
      PH_ZERO: ch = CH_ZERO;
      PH_DIG:  ch = digit_char(job_q.digits[dig_idx], job_q.upper);
      PH_PADR: ch = CH_SPACE;
      PH_IDLE: ch = CH_SPACE;
    endcase
  end

  assign chr_o.valid     = out_valid_q;
  assign chr_o.char_out  = char_q;
  assign chr_o.last_char = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy && pop_valid_i) begin
        job_q     <= pop_job_i;
        phase_q   <= first_phase(pop_job_i, 4'd0);
        seg_cnt_q <= '0;
        rem_q     <= pop_job_i.total;
      end else if (emit) begin
        rem_q <= rem_q - 1'b1;
        if (seg_end) begin
          phase_q   <= first_phase(job_q, {1'b0, phase_q} + 4'd1);
          seg_cnt_q <= '0;
        end else begin
          seg_cnt_q <= seg_cnt_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        char_q      <= ch;
        last_q      <= (rem_q == CNT_W'(1));
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `ITF_ASSERT_NXT(a_last_frees_seq, clk_i, rst_ni, emit && rem_q == CNT_W'(1), phase_q == PH_IDLE, "final character did not end the field")
  `ITF_ASSERT_IMP(a_busy_has_chars, clk_i, rst_ni, busy, rem_q != '0, "sequencer busy with no characters left")
  `ITF_ASSERT_IMP(a_digit_in_range, clk_i, rst_ni, phase_q == PH_DIG, in_digits, "digit index beyond digit count")

endmodule

// ===== hdl/integer_text_formatter.sv =====
// ---------------------------------------------------------------------------
// integer_text_formatter
// the front end takes octal and hex digits as bit groups and decimal ones
//   from a bcd conversion loop, scans them, then queues the field; it takes
//   a new request only once that field is queued; the emitter loads each
//   field, then gives one character per cycle while the receiver is ready
// reset: asynchronous, clears the handshakes and empties the queue
// ---------------------------------------------------------------------------
module integer_text_formatter (
  input  logic      clk_i,
  input  logic      rst_ni,
  itf_req_if.sink   req_i,
  itf_chr_if.source chr_o
);
  import itf_pkg::*;

  // front end: takes one request transaction, forms the magnitude and sign,
  // converts to digits (bit groups for octal/hex, shift-add-3 loop for
  // decimal), finds the digit count by scanning the digit register one
  // digit per cycle, then plans prefix, zero fill and padding
  logic push_valid, push_ready;
  job_t push_job;

  itf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // queue of planned fields lets the next conversion run while the
  // current field is still being emitted
  logic pop_valid, pop_ready;
  job_t pop_job;

  itf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // emitter: segment sequencer (left pad, sign, prefix, zero pad, precision
  // zeros, digits, right pad) into a registered character output; it keeps
  // producing while the consumer takes the previous transaction
  itf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .chr_o       (chr_o)
  );

endmodule

// ===== sim/integer_text_formatter_tb.sv =====
// ---------------------------------------------------------------------------
// integer_text_formatter_tb
// self-checking bench: drives format requests over the request channel and
// checks every emitted character and its last marker against a printf-style
// model kept in a small scoreboard, with random idling on both channels
// ---------------------------------------------------------------------------
module integer_text_formatter_tb;
  import itf_pkg::*;

  // run control
  localparam int RANDOM_ITEMS = 420;
  localparam int QUIET_FROM   = 370;      // last items run with no idling
  localparam int HOLD_AT      = 120;      // item index that starts the long stall
  localparam int DRAIN_AT     = 250;      // item index where the sender waits for all text
  localparam int LONG_HOLD    = 400;      // cycles the receiver holds off
  localparam int TAIL_CYCLES  = 120;      // extra wait after all expected text has come out
  localparam int CYCLE_LIMIT  = 1_500_000;

  // flag masks built from the package bit positions
  localparam logic [6:0] F_LEFT   = 7'(1 << FLAG_LEFT);
  localparam logic [6:0] F_PLUS   = 7'(1 << FLAG_PLUS);
  localparam logic [6:0] F_SPACE  = 7'(1 << FLAG_SPACE);
  localparam logic [6:0] F_ALT    = 7'(1 << FLAG_ALT);
  localparam logic [6:0] F_ZPAD   = 7'(1 << FLAG_ZPAD);
  localparam logic [6:0] F_LOWER  = 7'(1 << FLAG_LOWER);
  localparam logic [6:0] F_SIGNED = 7'(1 << FLAG_SIGNED);
  localparam logic [1:0] BASE_RSVD = 2'd3;  // reserved code, behaves as decimal

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  base;
    logic [6:0]  flags;
    logic [5:0]  width;
    logic [5:0]  prec;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // scoreboard: formats each accepted request into the characters it must
  // produce and checks the character stream in order
  class char_scoreboard;
    text_char_t  expected_text[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    function void note_request(fmt_req_t r);
      logic [63:0] mag;
      logic [63:0] orig_mag;
      logic [63:0] radix;
      logic [3:0]  d;
      logic [7:0]  c;
      logic [7:0]  rev[MAX_DIGITS];
      logic [7:0]  pre_ch[2];
      logic [7:0]  sign_ch;
      logic [7:0]  txt[$];
      text_char_t  e;
      bit          has_sign, left, lower, zpad;
      int          nd, npre, w, p, prec_n, zeros, len, pad, k;

      w      = int'(r.width);
      p      = int'(r.prec);
      left   = r.flags[FLAG_LEFT];
      lower  = r.flags[FLAG_LOWER];
      nd     = 0;
      npre   = 0;
      has_sign = 1'b0;
      sign_ch  = CH_SPACE;
      mag      = r.value;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (p > PREC_LIMIT) p = PREC_LIMIT;
      case (r.base)
        BASE_OCT: radix = 64'd8;
        BASE_HEX: radix = 64'd16;
        default:  radix = 64'd10;
      endcase

      // sign only applies to signed values; minus, then plus, then space
      if (r.flags[FLAG_SIGNED]) begin
        if (r.value[63]) begin
          has_sign = 1'b1;
          sign_ch  = CH_MINUS;
          mag      = 64'd0 - r.value;
        end else if (r.flags[FLAG_PLUS]) begin
          has_sign = 1'b1;
          sign_ch  = CH_PLUS;
        end else if (r.flags[FLAG_SPACE]) begin
          has_sign = 1'b1;
          sign_ch  = CH_SPACE;
        end
      end
      orig_mag = mag;

      // digits, least significant first, always at least one
      do begin
        d = 4'(mag % radix);
        c = (d < 10) ? CH_ZERO + 8'(d) : CH_LOW_A + 8'(d) - 8'd10;
        if (radix == 64'd16 && !lower && c >= CH_LOW_A) c = c & ~CASE_BIT;
        rev[nd] = c;
        nd++;
        mag = mag / radix;
      end while (mag != 64'd0 && nd < MAX_DIGITS);

      prec_n = (p == 0) ? 1 : p;
      zeros  = (prec_n > nd) ? prec_n - nd : 0;

      // alternate prefix: hex only for nonzero, octal only without a leading zero
      if (r.flags[FLAG_ALT]) begin
        if (radix == 64'd16 && orig_mag != 64'd0) begin
          pre_ch[0] = CH_ZERO;
          pre_ch[1] = lower ? (CH_UPX | CASE_BIT) : CH_UPX;
          npre = 2;
        end else if (radix == 64'd8 && zeros == 0 && rev[nd-1] != CH_ZERO) begin
          pre_ch[0] = CH_ZERO;
          npre = 1;
        end
      end

      len  = (has_sign ? 1 : 0) + npre + zeros + nd;
      pad  = (w > len) ? w - len : 0;
      zpad = r.flags[FLAG_ZPAD] && !left && p == 0;

      if (!left && !zpad) for (k = 0; k < pad; k++) txt.push_back(CH_SPACE);
      if (has_sign) txt.push_back(sign_ch);
      for (k = 0; k < npre; k++) txt.push_back(pre_ch[k]);
      if (zpad) for (k = 0; k < pad; k++) txt.push_back(CH_ZERO);
      for (k = 0; k < zeros; k++) txt.push_back(CH_ZERO);
      for (k = nd; k > 0; k--) txt.push_back(rev[k-1]);
      if (left) for (k = 0; k < pad; k++) txt.push_back(CH_SPACE);

      foreach (txt[i]) begin
        e.ch   = txt[i];
        e.last = (i == txt.size() - 1);
        expected_text.push_back(e);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t e;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, ch, last);
        errors++;
        return;
      end
      e = expected_text.pop_front();
      if (ch !== e.ch) begin
        $display("%0t: char_out mismatch: expected %h, actual %h", $time, e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_char mismatch: expected %b, actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic quiet;        // no idling on either side
  logic long_hold;    // asks the receiver for one long stall
  int   cycle_cnt;

  char_scoreboard sb;

  itf_req_if req_if();
  itf_chr_if chr_if();

  integer_text_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .chr_o  (chr_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog on the whole run
  initial begin : watchdog
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d characters outstanding", $time, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic fmt_req_t make_req(logic [63:0] v, logic [1:0] b, logic [6:0] f,
                                        logic [5:0] w, logic [5:0] p);
    fmt_req_t r;
    r.value = v;
    r.base  = b;
    r.flags = f;
    r.width = w;
    r.prec  = p;
    return r;
  endfunction

  // one request transaction, with an optional idle burst in front
  task automatic send_request(input fmt_req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.value        <= r.value;
    req_if.base_select  <= r.base;
    req_if.format_flags <= r.flags;
    req_if.field_width  <= r.width;
    req_if.min_digits   <= r.prec;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // stop offering and let every pending character come out
  task automatic wait_for_text();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // character receiver: checks each accepted transaction, then picks the
  // next ready value; short random stalls plus one long hold-off
  initial begin : char_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    chr_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      if (chr_if.valid && chr_if.ready) sb.check_char(chr_if.char_out, chr_if.last_char);
      if (long_hold && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        chr_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        chr_if.ready <= 1'b0;
      end else begin
        chr_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    fmt_req_t directed[$];
    fmt_req_t r;
    int       kind;

    sb = new();
    rst_ni              <= 1'b0;
    quiet               <= 1'b0;
    long_hold           <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.value        <= '0;
    req_if.base_select  <= BASE_DEC;
    req_if.format_flags <= '0;
    req_if.field_width  <= '0;
    req_if.min_digits   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero with no precision, and the prefix rules on zero
    directed.push_back(make_req(64'd0, BASE_DEC, 7'd0, 6'd0, 6'd0));
    directed.push_back(make_req(64'd0, BASE_HEX, F_ALT, 6'd0, 6'd0));
    directed.push_back(make_req(64'd0, BASE_OCT, F_ALT, 6'd0, 6'd0));
    directed.push_back(make_req(64'd0, BASE_OCT, F_ALT, 6'd0, 6'd5));
    // full-scale unsigned in every radix
    directed.push_back(make_req('1, BASE_DEC, 7'd0, 6'd0, 6'd0));
    directed.push_back(make_req('1, BASE_OCT, F_ALT, 6'd0, 6'd0));
    directed.push_back(make_req('1, BASE_HEX, F_ALT, 6'd0, 6'd0));
    directed.push_back(make_req(64'h0123_4567_89ab_cdef, BASE_HEX, F_ALT | F_LOWER,
                                6'd0, 6'd0));
    // most negative value, signed in decimal and hex
    directed.push_back(make_req(64'h8000_0000_0000_0000, BASE_DEC, F_SIGNED, 6'd0, 6'd0));
    directed.push_back(make_req(64'h8000_0000_0000_0000, BASE_HEX, F_SIGNED | F_ALT,
                                6'd0, 6'd0));
    // signed octal, zero padded
    directed.push_back(make_req('1, BASE_OCT, F_SIGNED | F_ZPAD, 6'd30, 6'd0));
    // plus wins over space; space alone; sign flags ignored when unsigned
    directed.push_back(make_req(64'd12345, BASE_DEC, F_SIGNED | F_PLUS | F_SPACE,
                                6'd0, 6'd0));
    directed.push_back(make_req(64'd12345, BASE_DEC, F_SIGNED | F_SPACE, 6'd0, 6'd0));
    directed.push_back(make_req(64'd12345, BASE_DEC, F_PLUS | F_SPACE, 6'd0, 6'd0));
    // reserved radix and decimal with alternate flag
    directed.push_back(make_req(64'd987654321, BASE_RSVD, 7'd0, 6'd0, 6'd0));
    directed.push_back(make_req(64'd987654321, BASE_DEC, F_ALT, 6'd12, 6'd0));
    // widest field, left justified and zero padded with sign and prefix
    directed.push_back(make_req(64'd42, BASE_DEC, F_LEFT, 6'd63, 6'd0));
    directed.push_back(make_req(64'hbeef, BASE_HEX, F_SIGNED | F_PLUS | F_ALT | F_ZPAD,
                                6'd63, 6'd0));
    // zero pad dropped with a precision or with left justify
    directed.push_back(make_req(64'd77, BASE_DEC, F_ZPAD, 6'd20, 6'd4));
    directed.push_back(make_req(64'd77, BASE_DEC, F_ZPAD | F_LEFT, 6'd20, 6'd0));
    // precision at the limit and beyond it
    directed.push_back(make_req(64'd5, BASE_DEC, 7'd0, 6'd0, 6'd60));
    directed.push_back(make_req(64'd5, BASE_HEX, F_ALT, 6'd63, 6'd63));
    // every flag at once
    directed.push_back(make_req(64'hffff_ffff_ffff_ff00, BASE_HEX, 7'h7f, 6'd63, 6'd0));
    directed.push_back(make_req(64'hffff_ffff_ffff_ff00, BASE_OCT, 7'h7f, 6'd0, 6'd0));

    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // receiver stalls long while requests keep coming, so the queue backs up
      if (n == HOLD_AT) long_hold <= 1'b1;
      // sender pauses once until all text has come out
      if (n == DRAIN_AT) wait_for_text();
      if (n == QUIET_FROM) quiet <= 1'b1;

      kind = $urandom_range(0, 9);
      case (kind)
        0:       r.value = 64'd0;
        1:       r.value = 64'($urandom_range(0, 999));
        2:       r.value = {32'hffff_ffff, $urandom};
        3:       r.value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 2));
        4:       r.value = 64'd1 << $urandom_range(0, 63);
        default: r.value = {$urandom, $urandom};
      endcase
      r.base  = 2'($urandom_range(0, 3));
      r.flags = 7'($urandom_range(0, 127));
      // mostly short fields, now and then any width up to the widest
      r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 20));
      case ($urandom_range(0, 4))
        0, 1:    r.prec = 6'd0;
        2, 3:    r.prec = 6'($urandom_range(1, 8));
        default: r.prec = 6'($urandom_range(0, 63));
      endcase
      send_request(r);
    end

    wait_for_text();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/itf_pkg.sv
hdl/itf_ifs.sv
hdl/itf_front.sv
hdl/itf_fifo.sv
hdl/itf_back.sv
hdl/integer_text_formatter.sv
sim/integer_text_formatter_tb.sv
